// ===== src/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg: shared types and codes of the software timer table
// Input and result word layouts, table entry layout, command and kind codes.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_FIRED  = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  localparam int TIME_W   = 48;
  localparam int PERIOD_W = 32;
  localparam int COUNT_W  = 5;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [7:0]          timer_id;
    logic                start_active;
    logic [TIME_W-1:0]   expiry_us;
    logic [PERIOD_W-1:0] reload_us;
    logic [TIME_W-1:0]   now_us;
  } in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic               ok;
    logic [7:0]         fired_id;
    logic [COUNT_W-1:0] entry_count;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [7:0]          id;
    logic                active;
    logic [TIME_W-1:0]   expiry;
    logic [PERIOD_W-1:0] period;
  } entry_t;

endpackage

// ===== src/software_timer_table.sv =====
// ----------------------------------------------------------------------------
// software_timer_table
// Table of periodic and one-shot timers kept in one synchronous memory.
// ----------------------------------------------------------------------------
// Words are taken one at a time. An add writes its entry when the word is taken
// and then answers from the response state. A remove walks the table one slot
// per cycle until the id matches, then reads the last slot and writes it into
// the freed one. A tick reads one slot per cycle while the result side accepts
// fired words, evaluates it in the next while the following slot is read, and
// writes back fired entries on the spare write port; a stalled result side holds
// the scan until the fired word is taken. The single read port of the entry
// memory sets the one slot per cycle pace.
module software_timer_table #(
  parameter int CAPACITY = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  stt_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output stt_pkg::out_t  out_data
);

  localparam int IW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int CW_EXT = (CW > stt_pkg::COUNT_W) ? CW : stt_pkg::COUNT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_MOVE = 3'd2;
  localparam logic [2:0] S_RESP = 3'd3;

  // entry memory
  stt_pkg::entry_t mem [CAPACITY];
  stt_pkg::entry_t rdata_r;
  logic            re;
  logic [IW-1:0]   raddr;
  logic            we;
  logic [IW-1:0]   waddr;
  stt_pkg::entry_t wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  logic [2:0]  state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic [IW-1:0] ev_idx_r, ev_idx_nxt;
  logic [IW-1:0] match_idx_r, match_idx_nxt;
  logic        pend_r, pend_nxt;
  logic [1:0]  cmd_r, cmd_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [stt_pkg::TIME_W-1:0] now_r, now_nxt;
  logic [1:0]  resp_kind_r, resp_kind_nxt;
  logic        resp_ok_r, resp_ok_nxt;
  logic        out_valid_r, out_valid_nxt;
  stt_pkg::out_t out_r, out_nxt;

  logic          can_push;
  logic          hit_tick;
  logic          hit_rm;
  logic [stt_pkg::TIME_W:0] sum;
  logic [CW_EXT-1:0] cnt_ext;
  logic [CW-1:0] cnt_last;

  assign can_push = !out_valid_r || out_ready;
  assign hit_tick = rdata_r.active && (now_r >= rdata_r.expiry);
  assign hit_rm   = (rdata_r.id == id_r);
  assign sum      = {1'b0, rdata_r.expiry}
                  + {{(stt_pkg::TIME_W - stt_pkg::PERIOD_W + 1){1'b0}}, rdata_r.period};
  assign cnt_last = cnt_r - CW'(1);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rd_idx_nxt    = rd_idx_r;
    ev_idx_nxt    = ev_idx_r;
    match_idx_nxt = match_idx_r;
    pend_nxt      = pend_r;
    cmd_nxt       = cmd_r;
    id_nxt        = id_r;
    now_nxt       = now_r;
    resp_kind_nxt = resp_kind_r;
    resp_ok_nxt   = resp_ok_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    in_ready      = 1'b0;
    re            = 1'b0;
    raddr         = rd_idx_r[IW-1:0];
    we            = 1'b0;
    waddr         = ev_idx_r;
    wdata         = rdata_r;
    cnt_ext       = '0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt    = in_data.cmd;
          id_nxt     = in_data.timer_id;
          now_nxt    = in_data.now_us;
          rd_idx_nxt = '0;
          pend_nxt   = 1'b0;
          case (in_data.cmd)
            stt_pkg::CMD_ADD: begin
              resp_kind_nxt = stt_pkg::KIND_ADD;
              resp_ok_nxt   = 1'b0;
              if (cnt_r < CW'(CAPACITY)) begin
                we            = 1'b1;
                waddr         = cnt_r[IW-1:0];
                wdata.id      = in_data.timer_id;
                wdata.active  = in_data.start_active;
                wdata.expiry  = in_data.expiry_us;
                wdata.period  = in_data.reload_us;
                cnt_nxt       = cnt_r + CW'(1);
                resp_ok_nxt   = 1'b1;
              end
              state_nxt = S_RESP;
            end
            stt_pkg::CMD_REMOVE: state_nxt = S_SCAN;
            stt_pkg::CMD_TICK:   state_nxt = S_SCAN;
            default:             state_nxt = S_IDLE;
          endcase
        end
      end

      S_SCAN: begin
        if (cmd_r == stt_pkg::CMD_TICK) begin
          if (!(pend_r && hit_tick && !can_push)) begin
            if (pend_r && hit_tick) begin
              out_valid_nxt        = 1'b1;
              out_nxt.kind         = stt_pkg::KIND_FIRED;
              out_nxt.ok           = 1'b1;
              out_nxt.fired_id     = rdata_r.id;
              cnt_ext              = CW_EXT'(cnt_r);
              out_nxt.entry_count  = cnt_ext[stt_pkg::COUNT_W-1:0];
              out_nxt.last         = 1'b0;
              we                   = 1'b1;
              if (rdata_r.period != '0) begin
                wdata.expiry = sum[stt_pkg::TIME_W] ? '1 : sum[stt_pkg::TIME_W-1:0];
              end else begin
                wdata.active = 1'b0;
              end
            end
            if (rd_idx_r < cnt_r) begin
              re         = 1'b1;
              ev_idx_nxt = rd_idx_r[IW-1:0];
              rd_idx_nxt = rd_idx_r + CW'(1);
              pend_nxt   = 1'b1;
            end else begin
              pend_nxt = 1'b0;
              if (!pend_r) begin
                resp_kind_nxt = stt_pkg::KIND_DONE;
                resp_ok_nxt   = 1'b1;
                state_nxt     = S_RESP;
              end
            end
          end
        end else begin
          if (pend_r && hit_rm) begin
            // found: fetch the last slot to fill the hole
            re            = 1'b1;
            raddr         = cnt_last[IW-1:0];
            match_idx_nxt = ev_idx_r;
            pend_nxt      = 1'b0;
            state_nxt     = S_MOVE;
          end else if (rd_idx_r < cnt_r) begin
            re         = 1'b1;
            ev_idx_nxt = rd_idx_r[IW-1:0];
            rd_idx_nxt = rd_idx_r + CW'(1);
            pend_nxt   = 1'b1;
          end else begin
            pend_nxt = 1'b0;
            if (!pend_r) begin
              resp_kind_nxt = stt_pkg::KIND_REMOVE;
              resp_ok_nxt   = 1'b0;
              state_nxt     = S_RESP;
            end
          end
        end
      end

      S_MOVE: begin
        we            = 1'b1;
        waddr         = match_idx_r;
        wdata         = rdata_r;
        cnt_nxt       = cnt_last;
        resp_kind_nxt = stt_pkg::KIND_REMOVE;
        resp_ok_nxt   = 1'b1;
        state_nxt     = S_RESP;
      end

      S_RESP: begin
        if (can_push) begin
          out_valid_nxt       = 1'b1;
          out_nxt.kind        = resp_kind_r;
          out_nxt.ok          = resp_ok_r;
          out_nxt.fired_id    = '0;
          cnt_ext             = CW_EXT'(cnt_r);
          out_nxt.entry_count = cnt_ext[stt_pkg::COUNT_W-1:0];
          out_nxt.last        = 1'b1;
          state_nxt           = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r    <= rd_idx_nxt;
    ev_idx_r    <= ev_idx_nxt;
    match_idx_r <= match_idx_nxt;
    cmd_r       <= cmd_nxt;
    id_r        <= id_nxt;
    now_r       <= now_nxt;
    resp_kind_r <= resp_kind_nxt;
    resp_ok_r   <= resp_ok_nxt;
    out_r       <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
